### src/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/uet_pkg.sv
// Types and constants for the unit expression tokenizer.
// Depends on nothing.
package uet_pkg;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_CARET = 8'h5E;

    localparam logic [5:0] MAX_EXPONENT_RESET = 6'd20;
    localparam logic [6:0] EXP_SATURATE       = 7'd127;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        EXP_START    = 2'd0,
        EXP_SIGNED   = 2'd1,
        EXP_DIGITS   = 2'd2,
        EXP_TRAILING = 2'd3
    } t_exp_phase;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_byte;
        logic [6:0]  exponent;
        logic        expression_valid;
        logic        last_of_run;
    } t_result;

endpackage

### src/unit_expression_tokenizer.sv
// Top level of the unit expression tokenizer: byte parser and result queue.
// Depends on uet_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Takes one byte of a unit expression per cycle while the input side is ready
// and emits name bytes, token ends with signed exponents and a final done word
// carrying the well-formed flag. Each accepted word is parsed in the cycle it
// is taken, and its results land in a four-entry output queue, so the first
// result is visible on the next cycle. The input side is ready while the queue
// holds two words or fewer, which sustains one input word per cycle as long as
// the output side drains one word per cycle; an end word closing a valid token
// yields two results. The configuration port is always ready.
module unit_expression_tokenizer
    import uet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [5:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_char_byte,
    input  logic              i_end_of_string,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_result_kind,
    output logic [7:0]        o_name_byte,
    output logic signed [6:0] o_exponent,
    output logic              o_expression_valid,
    output logic              o_last_of_run
);

    logic [5:0]  r_max_exponent;
    logic        r_in_denominator,   n_in_denominator;
    logic        r_segment_nonempty, n_segment_nonempty;
    logic        r_name_seen,        n_name_seen;
    logic        r_caret_seen,       n_caret_seen;
    t_exp_phase  r_exp_phase,        n_exp_phase;
    logic        r_exp_negative,     n_exp_negative;
    logic [6:0]  r_exp_value,        n_exp_value;
    logic        r_error_seen,       n_error_seen;

    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;

    logic        in_acc;
    logic        out_pop;
    logic        is_sep;
    logic        is_ws;
    logic        is_digit;
    logic        is_sign;
    logic        tok_ok;
    logic        tok_bad;
    logic [5:0]  tok_mag;
    logic [10:0] dig_acc;
    logic [6:0]  dig_sat;
    t_result     res0;
    t_result     res1;
    logic [1:0]  n_push;
    t_result     head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign out_pop     = o_out_valid && i_out_ready;

    assign is_sep   = (i_char_byte == CHAR_STAR) || (i_char_byte == CHAR_SLASH);
    assign is_ws    = ((i_char_byte >= CHAR_TAB) && (i_char_byte <= CHAR_CR))
                   || (i_char_byte == CHAR_SPACE);
    assign is_digit = (i_char_byte >= CHAR_ZERO) && (i_char_byte <= CHAR_NINE);
    assign is_sign  = (i_char_byte == CHAR_PLUS) || (i_char_byte == CHAR_MINUS);

    assign dig_acc = 11'(r_exp_value) * 11'd10 + 11'(i_char_byte - CHAR_ZERO);
    assign dig_sat = (dig_acc > 11'(EXP_SATURATE)) ? EXP_SATURATE : dig_acc[6:0];

    // Closing check of the current segment.
    always_comb begin
        tok_ok  = 1'b0;
        tok_bad = 1'b0;
        tok_mag = 6'd1;
        if (!r_error_seen && r_segment_nonempty) begin
            if (!r_caret_seen) begin
                tok_ok = r_name_seen;
            end else begin
                tok_ok = r_name_seen
                      && ((r_exp_phase == EXP_DIGITS) || (r_exp_phase == EXP_TRAILING))
                      && !r_exp_negative
                      && (r_exp_value != 7'd0)
                      && (r_exp_value <= 7'(r_max_exponent));
                tok_mag = r_exp_value[5:0];
            end
            tok_bad = !tok_ok;
        end
    end

    // Next state of the parser.
    always_comb begin
        n_in_denominator   = r_in_denominator;
        n_segment_nonempty = r_segment_nonempty;
        n_name_seen        = r_name_seen;
        n_caret_seen       = r_caret_seen;
        n_exp_phase        = r_exp_phase;
        n_exp_negative     = r_exp_negative;
        n_exp_value        = r_exp_value;
        n_error_seen       = r_error_seen;
        if (in_acc) begin
            priority if (i_end_of_string) begin
                n_in_denominator   = 1'b0;
                n_segment_nonempty = 1'b0;
                n_name_seen        = 1'b0;
                n_caret_seen       = 1'b0;
                n_exp_phase        = EXP_START;
                n_exp_negative     = 1'b0;
                n_exp_value        = 7'd0;
                n_error_seen       = 1'b0;
            end else if (is_sep) begin
                n_segment_nonempty = 1'b0;
                n_name_seen        = 1'b0;
                n_caret_seen       = 1'b0;
                n_exp_phase        = EXP_START;
                n_exp_negative     = 1'b0;
                n_exp_value        = 7'd0;
                n_error_seen       = r_error_seen || tok_bad;
                if (i_char_byte == CHAR_SLASH) begin
                    n_in_denominator = 1'b1;
                end
            end else if (is_ws) begin
                n_segment_nonempty = r_segment_nonempty;
            end else if (r_caret_seen) begin
                n_segment_nonempty = 1'b1;
                unique case (r_exp_phase)
                    EXP_START: begin
                        if (is_sign) begin
                            n_exp_negative = (i_char_byte == CHAR_MINUS);
                            n_exp_phase    = EXP_SIGNED;
                        end else if (is_digit) begin
                            n_exp_value = dig_sat;
                            n_exp_phase = EXP_DIGITS;
                        end else begin
                            n_error_seen = 1'b1;
                            n_exp_phase  = EXP_TRAILING;
                        end
                    end
                    EXP_SIGNED: begin
                        if (is_digit) begin
                            n_exp_value = dig_sat;
                            n_exp_phase = EXP_DIGITS;
                        end else begin
                            n_error_seen = 1'b1;
                            n_exp_phase  = EXP_TRAILING;
                        end
                    end
                    EXP_DIGITS: begin
                        if (is_digit) begin
                            n_exp_value = dig_sat;
                        end else begin
                            n_exp_phase = EXP_TRAILING;
                        end
                    end
                    default: begin
                        n_exp_phase = EXP_TRAILING;
                    end
                endcase
            end else if (i_char_byte == CHAR_CARET) begin
                n_segment_nonempty = 1'b1;
                n_caret_seen       = 1'b1;
            end else begin
                n_segment_nonempty = 1'b1;
                n_name_seen        = 1'b1;
            end
        end
    end

    // Results produced by the accepted word.
    always_comb begin
        res0   = '{kind: KIND_NAME, name_byte: 8'd0, exponent: 7'd0,
                   expression_valid: 1'b0, last_of_run: 1'b1};
        res1   = res0;
        n_push = 2'd0;
        if (in_acc) begin
            res0.exponent = r_in_denominator ? 7'(7'd0 - 7'(tok_mag)) : 7'(tok_mag);
            priority if (i_end_of_string) begin
                res1.kind             = KIND_DONE;
                res1.expression_valid = !(r_error_seen || tok_bad);
                if (tok_ok) begin
                    res0.kind        = KIND_TOKEN;
                    res0.last_of_run = 1'b0;
                    n_push           = 2'd2;
                end else begin
                    res0   = res1;
                    n_push = 2'd1;
                end
            end else if (is_sep) begin
                res0.kind = KIND_TOKEN;
                n_push    = tok_ok ? 2'd1 : 2'd0;
            end else if (!is_ws && !r_caret_seen && (i_char_byte != CHAR_CARET)) begin
                res0.exponent  = 7'd0;
                res0.name_byte = i_char_byte;
                n_push         = r_error_seen ? 2'd0 : 2'd1;
            end else begin
                n_push = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_exponent     <= MAX_EXPONENT_RESET;
            r_in_denominator   <= 1'b0;
            r_segment_nonempty <= 1'b0;
            r_name_seen        <= 1'b0;
            r_caret_seen       <= 1'b0;
            r_exp_phase        <= EXP_START;
            r_exp_negative     <= 1'b0;
            r_exp_value        <= 7'd0;
            r_error_seen       <= 1'b0;
            r_wr_ptr           <= '0;
            r_rd_ptr           <= '0;
            r_count            <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_exponent <= i_cfg_data;
            end
            r_in_denominator   <= n_in_denominator;
            r_segment_nonempty <= n_segment_nonempty;
            r_name_seen        <= n_name_seen;
            r_caret_seen       <= n_caret_seen;
            r_exp_phase        <= n_exp_phase;
            r_exp_negative     <= n_exp_negative;
            r_exp_value        <= n_exp_value;
            r_error_seen       <= n_error_seen;
            r_wr_ptr           <= r_wr_ptr + FIFO_AW'(n_push);
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= res1;
        end
    end

    assign head               = r_fifo[r_rd_ptr];
    assign o_result_kind      = head.kind;
    assign o_name_byte        = head.name_byte;
    assign o_exponent         = signed'(head.exponent);
    assign o_expression_valid = head.expression_valid;
    assign o_last_of_run      = head.last_of_run;

    `ASSERT_ALWAYS(a_fifo_bound, r_count <= (FIFO_AW+1)'(FIFO_DEPTH), "queue overflow")
    `ASSERT_NEXT(a_end_clears, in_acc && i_end_of_string,
        !r_error_seen && !r_in_denominator && !r_caret_seen && !r_segment_nonempty,
        "end word did not clear parser state")
    `ASSERT_NEXT(a_error_sticky, r_error_seen && !(in_acc && i_end_of_string),
        r_error_seen, "error flag dropped before end word")
    `ASSERT_IMPLY(a_token_nonzero, o_out_valid && (o_result_kind == KIND_TOKEN),
        o_exponent != 7'sd0, "token end with zero exponent")

endmodule

### tb/unit_expression_tokenizer_tb.sv
// Self-checking testbench for the unit expression tokenizer: random and directed expressions,
// a model of the parser that predicts every result word, and random idling on both sides.
// Depends on uet_pkg and the unit_expression_tokenizer RTL.
`timescale 1ns / 1ps

module unit_expression_tokenizer_tb;
    import uet_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [5:0]        i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_char_byte;
    logic              i_end_of_string;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [1:0]        o_result_kind;
    logic [7:0]        o_name_byte;
    logic signed [6:0] o_exponent;
    logic              o_expression_valid;
    logic              o_last_of_run;

    // Parser state as the testbench predicts it.
    logic       [5:0] power_limit    = MAX_EXPONENT_RESET;
    logic             denom_active   = 1'b0;
    logic             seg_has_text   = 1'b0;
    logic             seg_has_name   = 1'b0;
    logic             seg_has_caret  = 1'b0;
    t_exp_phase       power_phase    = EXP_START;
    logic             power_negative = 1'b0;
    logic       [6:0] power_value    = 7'd0;
    logic             expr_broken    = 1'b0;

    t_result    pending_results[$];
    t_result    oldest_expected;
    logic [7:0] expr_bytes[$];
    int         idle_pct    = 34;
    int         words_sent  = 0;
    int         mismatches  = 0;
    int         quiet_cycles = 0;

    unit_expression_tokenizer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_char_byte        (i_char_byte),
        .i_end_of_string    (i_end_of_string),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_kind      (o_result_kind),
        .o_name_byte        (o_name_byte),
        .o_exponent         (o_exponent),
        .o_expression_valid (o_expression_valid),
        .o_last_of_run      (o_last_of_run)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_result make_result(t_kind kind, logic [7:0] name_byte,
                                            logic [6:0] power, logic well_formed);
        t_result r;
        r.kind             = kind;
        r.name_byte        = name_byte;
        r.exponent         = power;
        r.expression_valid = well_formed;
        r.last_of_run      = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] random_name_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CHAR_STAR || b == CHAR_SLASH || b == CHAR_CARET || b == CHAR_SPACE
                   || (b >= CHAR_TAB && b <= CHAR_CR));
        return b;
    endfunction

    task automatic reset_segment_state();
        seg_has_text   = 1'b0;
        seg_has_name   = 1'b0;
        seg_has_caret  = 1'b0;
        power_phase    = EXP_START;
        power_negative = 1'b0;
        power_value    = 7'd0;
    endtask

    task automatic finish_segment(output logic emit, output logic [6:0] power);
        logic bad;
        emit  = 1'b0;
        power = 7'd0;
        if (!expr_broken && seg_has_text) begin
            bad   = !seg_has_name;
            power = 7'd1;
            if (seg_has_caret) begin
                if (power_phase == EXP_START || power_phase == EXP_SIGNED || power_negative
                    || power_value == 7'd0 || power_value > {1'b0, power_limit}) begin
                    bad = 1'b1;
                end else begin
                    power = power_value;
                end
            end
            if (bad) begin
                expr_broken = 1'b1;
            end else begin
                emit = 1'b1;
                if (denom_active) begin
                    power = 7'd0 - power;
                end
            end
        end
        reset_segment_state();
    endtask

    task automatic tokenize_word(input logic [7:0] ch, input logic eos);
        t_result    produced[$];
        logic [6:0] power;
        logic       emit;
        int         acc;
        if (eos) begin
            finish_segment(emit, power);
            if (emit) begin
                produced = {produced, make_result(KIND_TOKEN, 8'd0, power, 1'b0)};
            end
            produced = {produced, make_result(KIND_DONE, 8'd0, 7'd0, !expr_broken)};
            denom_active = 1'b0;
            expr_broken  = 1'b0;
        end else if (ch == CHAR_STAR || ch == CHAR_SLASH) begin
            finish_segment(emit, power);
            if (emit) begin
                produced = {produced, make_result(KIND_TOKEN, 8'd0, power, 1'b0)};
            end
            if (ch == CHAR_SLASH) begin
                denom_active = 1'b1;
            end
        end else if ((ch >= CHAR_TAB && ch <= CHAR_CR) || ch == CHAR_SPACE) begin
            // Whitespace is dropped wherever it appears.
        end else if (seg_has_caret) begin
            seg_has_text = 1'b1;
            if (power_phase == EXP_START && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
                power_negative = (ch == CHAR_MINUS);
                power_phase    = EXP_SIGNED;
            end else if (power_phase != EXP_TRAILING) begin
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                    acc         = int'(power_value) * 10 + int'(ch - CHAR_ZERO);
                    power_value = (acc > 127) ? EXP_SATURATE : 7'(acc);
                    power_phase = EXP_DIGITS;
                end else begin
                    if (power_phase != EXP_DIGITS) begin
                        expr_broken = 1'b1;
                    end
                    power_phase = EXP_TRAILING;
                end
            end
        end else if (ch == CHAR_CARET) begin
            seg_has_text  = 1'b1;
            seg_has_caret = 1'b1;
        end else begin
            seg_has_text = 1'b1;
            seg_has_name = 1'b1;
            if (!expr_broken) begin
                produced = {produced, make_result(KIND_NAME, ch, 7'd0, 1'b0)};
            end
        end
        if (produced.size() != 0) begin
            produced[produced.size() - 1].last_of_run = 1'b1;
        end
        pending_results = {pending_results, produced};
    endtask

    task automatic send_word(input logic [7:0] ch, input logic eos);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_char_byte     <= ch;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        tokenize_word(ch, eos);
        if (eos || !((ch >= CHAR_TAB && ch <= CHAR_CR) || ch == CHAR_SPACE)) begin
            words_sent++;
        end
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_word(text[i], 1'b0);
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_expression();
        foreach (expr_bytes[i]) begin
            send_word(expr_bytes[i], 1'b0);
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_power_limit(input logic [5:0] new_limit);
        hold_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= new_limit;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        power_limit = new_limit;
    endtask

    // Mostly well-formed expressions; a few have broken exponents or stray bytes.
    task automatic build_random_expression();
        int    segments;
        int    choice;
        int    magnitude;
        int    ws;
        string digits;
        expr_bytes.delete();
        segments = $urandom_range(0, 4);
        for (int s = 0; s < segments; s++) begin
            if (s != 0 || $urandom_range(0, 9) == 0) begin
                expr_bytes = {expr_bytes,
                              ($urandom_range(0, 1) != 0) ? CHAR_STAR : CHAR_SLASH};
            end
            if ($urandom_range(0, 9) == 0) begin
                ws = $urandom_range(0, 5);
                expr_bytes = {expr_bytes, (ws == 5) ? CHAR_SPACE : 8'(CHAR_TAB + 8'(ws))};
            end
            if ($urandom_range(0, 19) != 0) begin
                repeat ($urandom_range(1, 4)) expr_bytes = {expr_bytes, random_name_byte()};
            end
            if ($urandom_range(0, 2) == 0) begin
                expr_bytes = {expr_bytes, CHAR_CARET};
                choice = $urandom_range(0, 9);
                if (choice == 0) begin
                    expr_bytes = {expr_bytes, CHAR_MINUS};
                end else if (choice == 1) begin
                    expr_bytes = {expr_bytes, CHAR_PLUS};
                end
                choice = $urandom_range(0, 19);
                if (choice == 0) begin
                    magnitude = -1;
                end else if (choice == 1) begin
                    magnitude = 0;
                end else if (choice == 2) begin
                    magnitude = int'(power_limit) + 1 + $urandom_range(0, 30);
                end else if (choice == 3) begin
                    magnitude = $urandom_range(128, 9999);
                end else if (power_limit == 6'd0) begin
                    magnitude = $urandom_range(1, 9);
                end else begin
                    magnitude = $urandom_range(1, int'(power_limit));
                end
                if (magnitude >= 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        expr_bytes = {expr_bytes, CHAR_ZERO};
                    end
                    digits = $sformatf("%0d", magnitude);
                    for (int i = 0; i < digits.len(); i++) begin
                        expr_bytes = {expr_bytes, 8'(digits[i])};
                    end
                end
                if ($urandom_range(0, 4) == 0) begin
                    expr_bytes = {expr_bytes, 8'($urandom_range(0, 255))};
                end
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                expr_bytes.insert($urandom_range(0, expr_bytes.size()),
                                  8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic run_random_expressions(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target) begin
            build_random_expression();
            send_expression();
        end
    endtask

    task automatic test_directed_cases();
        send_word(8'hFF, 1'b1);
        send_text("a^2 /b");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("^-1*q");
        send_text("**m^020x");
    endtask

    task automatic test_max_exponent_zero();
        write_power_limit(6'd0);
        run_random_expressions(120);
    endtask

    task automatic test_max_exponent_extremes();
        write_power_limit(6'd63);
        run_random_expressions(350);
        write_power_limit(6'd1);
        run_random_expressions(250);
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        write_power_limit(6'($urandom_range(1, 63)));
        run_random_expressions(350);
        idle_pct = 34;
    endtask

    task automatic test_pause_mid_expression();
        int half;
        write_power_limit(MAX_EXPONENT_RESET);
        repeat (20) begin
            build_random_expression();
            half = expr_bytes.size() / 2;
            for (int i = 0; i < expr_bytes.size(); i++) begin
                if (i == half) begin
                    hold_until_drained();
                end
                send_word(expr_bytes[i], 1'b0);
            end
            send_word(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic test_random_expressions();
        write_power_limit(6'($urandom_range(2, 62)));
        run_random_expressions(300);
        write_power_limit(MAX_EXPONENT_RESET);
        run_random_expressions(300);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: kind %0d byte %h exp %0d valid %b last %b",
                             o_result_kind, o_name_byte, o_exponent, o_expression_valid,
                             o_last_of_run);
                end
            end else begin
                oldest_expected = pending_results.pop_front();
                if (o_result_kind !== oldest_expected.kind
                    || o_name_byte !== oldest_expected.name_byte
                    || o_exponent !== oldest_expected.exponent
                    || o_expression_valid !== oldest_expected.expression_valid
                    || o_last_of_run !== oldest_expected.last_of_run) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind %0d byte %h exp %0d valid %b last %b",
                                 oldest_expected.kind, oldest_expected.name_byte,
                                 $signed(oldest_expected.exponent),
                                 oldest_expected.expression_valid,
                                 oldest_expected.last_of_run);
                        $display("          actual   kind %0d byte %h exp %0d valid %b last %b",
                                 o_result_kind, o_name_byte, o_exponent, o_expression_valid,
                                 o_last_of_run);
                    end
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("unit_expression_tokenizer_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= 6'd0;
        i_in_valid      <= 1'b0;
        i_char_byte     <= 8'd0;
        i_end_of_string <= 1'b0;
        i_out_ready     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_max_exponent_zero();
        test_max_exponent_extremes();
        test_back_to_back();
        test_pause_mid_expression();
        test_random_expressions();
        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("unit_expression_tokenizer_tb passed");
        end else begin
            $display("unit_expression_tokenizer_tb failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/uet_pkg.sv
src/unit_expression_tokenizer.sv
tb/unit_expression_tokenizer_tb.sv
